// ===== sv/sjh_pkg.sv =====
// Shared types, constants and helpers of the stereo joint histogram unit.
`default_nettype none

package sjh_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int LEVELS_DEF    = 256;

  // Column fields in the queue are sized for the largest supported row
  localparam int COL_W = 13;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  SAT_LIMIT  = 8'd255;
  localparam int          READ_SHIFT = 7;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  localparam int              EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } sjh_mode_e;

  typedef struct packed {
    sjh_mode_e        mode;
    logic [7:0]       lp;
    logic [7:0]       rp;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] target;
    logic [7:0]       bl;
    logic [7:0]       br;
    logic             row_end;
    logic             last;
  } sjh_item_t;

  function automatic logic [7:0] clip_level(input logic [7:0] v, input logic [8:0] lim);
    return ({1'b0, v} >= lim) ? 8'(lim - 9'd1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sjh_if.sv =====
// Handshake channels for pixel/command beats and result beats.
`default_nettype none

interface sjh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;
  logic [7:0] disparity;
  logic [7:0] bin_left;
  logic [7:0] bin_right;

  modport source (output valid, mode, left_pixel, right_pixel, disparity, bin_left,
                  bin_right, input ready);
  modport sink (input valid, mode, left_pixel, right_pixel, disparity, bin_left,
                bin_right, output ready);
endinterface

interface sjh_out_if;
  logic        valid;
  logic        ready;
  logic        counted;
  logic        last_pixel;
  logic [14:0] joint_weighted;
  logic [15:0] left_total;
  logic [15:0] right_total;

  modport source (output valid, counted, last_pixel, joint_weighted, left_total,
                  right_total, input ready);
  modport sink (input valid, counted, last_pixel, joint_weighted, left_total,
                right_total, output ready);
endinterface

`default_nettype wire

// ===== sv/stereo_joint_histogram_unit.sv =====
// Top level of the stereo joint histogram unit: config registers, front end, queue, engine.
`default_nettype none

// Builds the joint left/right intensity histogram of a stereo pair under a disparity
// map, from raster-order pixel beats; read beats return one bin times 128 with its row
// and column marginals, clear beats empty the histogram. Every accepted beat yields one
// result beat. Each beat passes three engine steps (pop with row-store and tag read,
// bin and marginal lookup, update and result), set by the read-modify-write of the
// histogram memories, and the update waits while the last result is not taken; a
// two-entry queue lets the front keep taking beats meanwhile. After reset and after
// each clear beat a clearing pass over the histogram and tags runs and no beat is
// accepted; every 255 rows the occlusion tags take a pass over all MAX_WIDTH entries.
// Registers: image_width at byte address 0, image_height at 4.
module stereo_joint_histogram_unit import sjh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sjh_in_if.sink      in_ch,
  sjh_out_if.source   out_ch
);

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic        cfg_wr;
  logic        push, pop, q_full, q_empty, sweeping;
  sjh_item_t   item, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, height_q} : {21'd0, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[15:0];
      endcase
    end
  end

  sjh_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .LEVELS    (LEVELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .sweeping_i     (sweeping),
    .full_i         (q_full),
    .push_o         (push),
    .item_o         (item)
  );

  sjh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  sjh_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .LEVELS    (LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .sweeping_o (sweeping),
    .out_ch     (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue written while full");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweeping |-> !(in_ch.valid && in_ch.ready))
    else $error("beat accepted during clearing pass");

  a_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.counted || out_ch.last_pixel)) |->
      (out_ch.joint_weighted == 15'd0 && out_ch.left_total == 16'd0 &&
       out_ch.right_total == 16'd0))
    else $error("pixel result carries read fields");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty && !sweeping)
    else $error("engine popped an empty queue");
`endif

endmodule

`default_nettype wire

// ===== sv/sjh_front.sv =====
// Front end: accepts beats, tracks raster position, clips levels, builds queue entries.
`default_nettype none

module sjh_front import sjh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sjh_in_if.sink      in_ch,
  input  logic [10:0] image_width_i,
  input  logic [15:0] image_height_i,
  input  logic        sweeping_i,
  input  logic        full_i,
  output logic        push_o,
  output sjh_item_t   item_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CmpW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int TW   = (CW > 8) ? CW : 8;

  logic [CW-1:0]   col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [CmpW-1:0] col_nx;
  logic [16:0]     row_nx;
  logic [TW-1:0]   col_t, disp_t;
  logic [CW-1:0]   target;
  logic            row_end, wrap, accept;
  sjh_mode_e       mode;

  assign mode     = sjh_mode_e'(in_ch.mode);
  assign in_ch.ready = !full_i && !sweeping_i;
  assign accept   = in_ch.valid && in_ch.ready;
  assign push_o   = accept;

  assign col_nx  = CmpW'(col_q) + CmpW'(1);
  assign row_end = (image_width_i == 11'd0) || (col_nx >= CmpW'(image_width_i)) ||
                   (col_nx >= CmpW'(MAX_WIDTH));
  assign row_nx  = {1'b0, row_q} + 17'd1;
  assign wrap    = (image_height_i == 16'd0) || (row_nx >= {1'b0, image_height_i});

  assign col_t  = TW'(col_q);
  assign disp_t = TW'(in_ch.disparity);
  assign target = (col_t > disp_t) ? CW'(col_t - disp_t) : col_q;

  always_comb begin
    item_o.mode    = mode;
    item_o.lp      = clip_level(in_ch.left_pixel, 9'(LEVELS));
    item_o.rp      = in_ch.right_pixel;
    item_o.col     = COL_W'(col_q);
    item_o.target  = COL_W'(target);
    item_o.bl      = clip_level(in_ch.bin_left, 9'(LEVELS));
    item_o.br      = clip_level(in_ch.bin_right, 9'(LEVELS));
    item_o.row_end = row_end;
    item_o.last    = row_end && wrap;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      unique case (mode)
        MODE_PIXEL: begin
          if (row_end) begin
            col_d = '0;
            row_d = wrap ? 16'd0 : row_nx[15:0];
          end else begin
            col_d = CW'(col_nx);
          end
        end
        MODE_CLEAR: begin
          col_d = '0;
          row_d = '0;
        end
        MODE_READ, MODE_NOP: begin
          col_d = col_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sjh_queue.sv =====
// Short FIFO between the front end and the histogram engine.
`default_nettype none

module sjh_queue import sjh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sjh_item_t item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output sjh_item_t head_o
);

  sjh_item_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PW:0]    cnt_q;

  assign full_o  = cnt_q == (QUEUE_PW + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_PW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QUEUE_PW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QUEUE_PW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sjh_back.sv =====
// Histogram engine: row store, occlusion tags, joint bins and marginals, clear sweeps.
`default_nettype none

module sjh_back import sjh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sjh_item_t head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      sweeping_o,
  sjh_out_if.source out_ch
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int LW        = $clog2(LEVELS);
  localparam int JW        = 2 * LW;
  localparam int JDEPTH    = 1 << JW;
  localparam int SWEEP_LEN = (JDEPTH > MAX_WIDTH) ? JDEPTH : MAX_WIDTH;
  localparam int SW        = $clog2(SWEEP_LEN);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [7:0]         joint_mem [JDEPTH];
  logic [15:0]        lmarg_mem [LEVELS];
  logic [15:0]        rmarg_mem [LEVELS];
  logic [7:0]         row_mem   [MAX_WIDTH];
  logic [EPOCH_W-1:0] tag_mem   [MAX_WIDTH];

  logic [1:0]         state_q;
  logic [SW-1:0]      sweep_cnt_q;
  logic               sweep_full_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic               out_valid_q;

  sjh_item_t          work_q;
  logic               fwd_q;
  logic [7:0]         row_rd_q;
  logic [EPOCH_W-1:0] tag_rd_q;
  logic [7:0]         joint_rd_q;
  logic [15:0]        lmarg_rd_q, rmarg_rd_q;
  logic [LW-1:0]      rv_q;

  logic               counted_q, last_q;
  logic [14:0]        jw_q;
  logic [15:0]        lt_q, rt_q;

  logic               sweeping, look, upd_fire, is_pix, is_read, occ, hit, grow;
  logic               sweep_done, lt_j, lt_l, lt_w;
  logic [7:0]         rv_full;
  logic [LW-1:0]      rv_lk, lp_w;
  logic [JW-1:0]      j_ra, j_wa;
  logic [LW-1:0]      l_ra, r_ra, l_wa, r_wa;
  logic [CW-1:0]      t_wa;
  logic               j_we, l_we, r_we, t_we, row_we;
  logic [7:0]         j_wd;
  logic [15:0]        l_wd, r_wd;
  logic [EPOCH_W-1:0] t_wd;

  assign sweeping   = state_q == ST_SWEEP;
  assign sweeping_o = sweeping;
  assign look       = state_q == ST_LOOK;
  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign row_we     = pop_o && (head_i.mode == MODE_PIXEL);
  assign upd_fire   = (state_q == ST_UPD) && (!out_valid_q || out_ch.ready);

  assign is_pix  = work_q.mode == MODE_PIXEL;
  assign is_read = work_q.mode == MODE_READ;
  assign lp_w    = work_q.lp[LW-1:0];

  // Lookup: right level comes from the row store, or straight from this beat
  assign rv_full = clip_level(fwd_q ? work_q.rp : row_rd_q, 9'(LEVELS));
  assign rv_lk   = rv_full[LW-1:0];
  assign j_ra    = is_pix ? {lp_w, rv_lk} : {work_q.bl[LW-1:0], work_q.br[LW-1:0]};
  assign l_ra    = is_pix ? lp_w : work_q.bl[LW-1:0];
  assign r_ra    = is_pix ? rv_lk : work_q.br[LW-1:0];

  // Update
  assign occ  = tag_rd_q == epoch_q;
  assign hit  = upd_fire && is_pix && !occ;
  assign grow = hit && (joint_rd_q != SAT_LIMIT);

  // Sweep
  assign lt_j = {1'b0, sweep_cnt_q} < (SW + 1)'(JDEPTH);
  assign lt_l = {1'b0, sweep_cnt_q} < (SW + 1)'(LEVELS);
  assign lt_w = {1'b0, sweep_cnt_q} < (SW + 1)'(MAX_WIDTH);
  assign sweep_done = sweep_cnt_q == (sweep_full_q ? SW'(SWEEP_LEN - 1) : SW'(MAX_WIDTH - 1));

  assign j_we = grow || (sweeping && sweep_full_q && lt_j);
  assign j_wa = sweeping ? sweep_cnt_q[JW-1:0] : {lp_w, rv_q};
  assign j_wd = sweeping ? 8'd0 : joint_rd_q + 8'd1;
  assign l_we = grow || (sweeping && sweep_full_q && lt_l);
  assign l_wa = sweeping ? sweep_cnt_q[LW-1:0] : lp_w;
  assign l_wd = sweeping ? 16'd0 : lmarg_rd_q + 16'd1;
  assign r_we = grow || (sweeping && sweep_full_q && lt_l);
  assign r_wa = sweeping ? sweep_cnt_q[LW-1:0] : rv_q;
  assign r_wd = sweeping ? 16'd0 : rmarg_rd_q + 16'd1;
  assign t_we = hit || (sweeping && lt_w);
  assign t_wa = sweeping ? sweep_cnt_q[CW-1:0] : work_q.target[CW-1:0];
  assign t_wd = sweeping ? '0 : epoch_q;

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[head_i.col[CW-1:0]] <= head_i.rp;
    if (pop_o)  row_rd_q <= row_mem[head_i.target[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (t_we)  tag_mem[t_wa] <= t_wd;
    if (pop_o) tag_rd_q <= tag_mem[head_i.target[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (j_we) joint_mem[j_wa] <= j_wd;
    if (look) joint_rd_q <= joint_mem[j_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lmarg_mem[l_wa] <= l_wd;
    if (look) lmarg_rd_q <= lmarg_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) rmarg_mem[r_wa] <= r_wd;
    if (look) rmarg_rd_q <= rmarg_mem[r_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= head_i;
      fwd_q  <= head_i.target == head_i.col;
    end
    if (look) rv_q <= rv_lk;
    if (upd_fire) begin
      counted_q <= hit;
      last_q    <= is_pix && work_q.last;
      jw_q      <= is_read ? (15'(joint_rd_q) << READ_SHIFT) : 15'd0;
      lt_q      <= is_read ? lmarg_rd_q : 16'd0;
      rt_q      <= is_read ? rmarg_rd_q : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_cnt_q  <= '0;
      sweep_full_q <= 1'b1;
      epoch_q      <= EPOCH_FIRST;
      out_valid_q  <= 1'b0;
    end else begin
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_SWEEP: begin
          if (sweep_done) begin
            state_q <= ST_IDLE;
          end else begin
            sweep_cnt_q <= sweep_cnt_q + SW'(1);
          end
        end
        ST_IDLE: begin
          if (!empty_i) state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_fire) begin
            priority if (work_q.mode == MODE_CLEAR) begin
              state_q      <= ST_SWEEP;
              sweep_full_q <= 1'b1;
              sweep_cnt_q  <= '0;
              epoch_q      <= EPOCH_FIRST;
            end else if (is_pix && work_q.row_end && epoch_q == EPOCH_LAST) begin
              state_q      <= ST_SWEEP;
              sweep_full_q <= 1'b0;
              sweep_cnt_q  <= '0;
              epoch_q      <= EPOCH_FIRST;
            end else begin
              state_q <= ST_IDLE;
              if (is_pix && work_q.row_end) epoch_q <= epoch_q + EPOCH_W'(1);
            end
          end
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.counted        = counted_q;
  assign out_ch.last_pixel     = last_q;
  assign out_ch.joint_weighted = jw_q;
  assign out_ch.left_total     = lt_q;
  assign out_ch.right_total    = rt_q;

endmodule

`default_nettype wire

// ===== dv/stereo_joint_histogram_unit_tb.sv =====
// Self-checking testbench: directed table plus random pixel/read/no-op beats and clears vs. a histogram model.
module stereo_joint_histogram_unit_tb import sjh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          MAX_GAP     = 12;
  localparam int          HOLD_CYCLES = 300;
  localparam int          MAX_COLS    = MAX_WIDTH_DEF;
  localparam logic [7:0]  SAT_LEFT    = 8'h3C;
  localparam logic [7:0]  SAT_RIGHT   = 8'hC3;

  typedef struct packed {
    sjh_mode_e  mode;
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
    logic [7:0] disparity;
    logic [7:0] bin_left;
    logic [7:0] bin_right;
  } beat_t;

  typedef struct packed {
    logic        counted;
    logic        last_pixel;
    logic [14:0] joint_weighted;
    logic [15:0] left_total;
    logic [15:0] right_total;
  } hist_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sjh_in_if  pix_if ();
  sjh_out_if res_if ();

  stereo_joint_histogram_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (pix_if),
    .out_ch  (res_if)
  );

  // histogram model state
  logic [7:0]  joint_hist [0:65535];
  logic [15:0] left_marg  [0:255];
  logic [15:0] right_marg [0:255];
  logic [7:0]  row_buf    [0:MAX_COLS-1];
  bit          occl_mark  [0:MAX_COLS-1];
  logic [9:0]  col_pos;
  logic [15:0] row_pos;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  recent_lp;
  logic [7:0]  recent_rv;

  hist_result_t pending_results [$];
  beat_t        dir_beats [$];
  bit           dir_typed [$];
  hist_result_t dir_expect [$];

  bit          idle_en;
  bit          hold_off_req;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned sat_hits;
  int unsigned occluded_pairs;
  int unsigned beats_by_mode [4];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $error("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
           pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic void clear_hist();
    foreach (joint_hist[i]) joint_hist[i] = '0;
    foreach (left_marg[i]) left_marg[i] = '0;
    foreach (right_marg[i]) right_marg[i] = '0;
    foreach (occl_mark[i]) occl_mark[i] = 1'b0;
    col_pos = '0;
    row_pos = '0;
  endfunction

  function automatic hist_result_t predict_histogram_result(beat_t b);
    hist_result_t r;
    logic [9:0]   col;
    logic [9:0]   target;
    logic [7:0]   rv;
    logic [15:0]  idx;
    int unsigned  eff_w;
    int unsigned  eff_h;
    r = '0;
    case (b.mode)
      MODE_PIXEL: begin
        col = col_pos;
        row_buf[col] = b.right_pixel;
        target = (col > b.disparity) ? col - b.disparity : col;
        if (!occl_mark[target]) begin
          rv = row_buf[target];
          idx = {b.left_pixel, rv};
          r.counted = 1'b1;
          occl_mark[target] = 1'b1;
          recent_lp = b.left_pixel;
          recent_rv = rv;
          if (joint_hist[idx] < SAT_LIMIT) begin
            joint_hist[idx] = joint_hist[idx] + 8'd1;
            left_marg[b.left_pixel] = left_marg[b.left_pixel] + 16'd1;
            right_marg[rv] = right_marg[rv] + 16'd1;
          end else begin
            sat_hits++;
          end
        end else begin
          occluded_pairs++;
        end
        eff_w = (width_reg == 0) ? 1 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
        eff_h = (height_reg == 0) ? 1 : height_reg;
        if (32'(col) + 1 >= eff_w) begin
          foreach (occl_mark[i]) occl_mark[i] = 1'b0;
          col_pos = '0;
          if (32'(row_pos) + 1 >= eff_h) begin
            row_pos = '0;
            r.last_pixel = 1'b1;
          end else begin
            row_pos = row_pos + 16'd1;
          end
        end else begin
          col_pos = col + 10'd1;
        end
      end
      MODE_READ: begin
        r.joint_weighted = {joint_hist[{b.bin_left, b.bin_right}], 7'b0};
        r.left_total = left_marg[b.bin_left];
        r.right_total = right_marg[b.bin_right];
      end
      MODE_CLEAR: clear_hist();
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(sjh_mode_e m, logic [7:0] lp, logic [7:0] rp,
                                  logic [7:0] d, logic [7:0] bl, logic [7:0] br,
                                  bit typed, logic c, logic lst, logic [14:0] jw,
                                  logic [15:0] lt, logic [15:0] rt);
    beat_t        b;
    hist_result_t r;
    b = {m, lp, rp, d, bl, br};
    r = {c, lst, jw, lt, rt};
    dir_beats.push_back(b);
    dir_typed.push_back(typed);
    dir_expect.push_back(r);
  endfunction

  function automatic beat_t make_beat(bit narrow, bit fixed_bin);
    beat_t       b;
    int unsigned pick;
    b = '0;
    pick = $urandom_range(0, 99);
    b.left_pixel = $urandom_range(0, 255);
    b.right_pixel = $urandom_range(0, 255);
    b.disparity = $urandom_range(0, 255);
    b.bin_left = $urandom_range(0, 255);
    b.bin_right = $urandom_range(0, 255);
    if (pick < 15) begin
      b.mode = MODE_READ;
      if (pick < 8) begin
        b.bin_left = recent_lp;
        b.bin_right = recent_rv;
      end else if (narrow) begin
        b.bin_left = $urandom_range(0, 7);
        b.bin_right = $urandom_range(0, 7);
      end
    end else if (pick < 17) begin
      b.mode = MODE_NOP;
    end else begin
      b.mode = MODE_PIXEL;
      if (fixed_bin) begin
        b.left_pixel = SAT_LEFT;
        b.right_pixel = SAT_RIGHT;
      end else if (narrow) begin
        b.left_pixel = $urandom_range(0, 7);
        b.right_pixel = $urandom_range(0, 7);
      end
      if (pick < 60) b.disparity = $urandom_range(0, 3);
    end
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input hist_result_t given);
    int unsigned  gap;
    hist_result_t pred;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid = 1'b1;
    pix_if.mode = b.mode;
    pix_if.left_pixel = b.left_pixel;
    pix_if.right_pixel = b.right_pixel;
    pix_if.disparity = b.disparity;
    pix_if.bin_left = b.bin_left;
    pix_if.bin_right = b.bin_right;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    pred = predict_histogram_result(b);
    pending_results.push_back(typed ? given : pred);
    beats_by_mode[b.mode]++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    if (reg_idx == REG_WIDTH) width_reg = value[10:0];
    else height_reg = value[15:0];
    stored = (reg_idx == REG_WIDTH) ? {21'd0, width_reg} : {16'd0, height_reg};
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== stored) begin
      $error("prdata: expected %0d, actual %0d", stored, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_phase(input logic [10:0] w, input logic [15:0] h, input int n,
                           input bit narrow, input bit fixed_bin, input bit idle,
                           input bit hold, input bit mid_clear);
    beat_t        b;
    hist_result_t none;
    none = '0;
    write_reg(REG_WIDTH, {21'd0, w});
    write_reg(REG_HEIGHT, {16'd0, h});
    idle_en = idle;
    hold_off_req = hold;
    for (int i = 0; i < n; i++) begin
      if (mid_clear && i == n / 2) begin
        b = '0;
        b.mode = MODE_CLEAR;
      end else begin
        b = make_beat(narrow, fixed_bin);
      end
      send_beat(b, 1'b0, none);
    end
    drain_results();
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    hist_result_t want;
    int unsigned  stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stall = idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (stall != 0) begin
          res_if.ready = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no expected result pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("counted", want.counted, res_if.counted);
        check_field("last_pixel", want.last_pixel, res_if.last_pixel);
        check_field("joint_weighted", want.joint_weighted, res_if.joint_weighted);
        check_field("left_total", want.left_total, res_if.left_total);
        check_field("right_total", want.right_total, res_if.right_total);
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_if.valid = 1'b0;
    pix_if.mode = MODE_NOP;
    pix_if.left_pixel = '0;
    pix_if.right_pixel = '0;
    pix_if.disparity = '0;
    pix_if.bin_left = '0;
    pix_if.bin_right = '0;
    idle_en = 1'b1;
    hold_off_req = 1'b0;
    mismatches = 0;
    results_checked = 0;
    sat_hits = 0;
    occluded_pairs = 0;
    foreach (beats_by_mode[i]) beats_by_mode[i] = 0;
    recent_lp = '0;
    recent_rv = '0;
    clear_hist();
    foreach (row_buf[i]) row_buf[i] = '0;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(REG_WIDTH, 32'd4);
    write_reg(REG_HEIGHT, 32'd2);

    // 4-wide, 2-row frame: occlusion, zero-offset pairing, end of frame
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_NOP,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, 1, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   1, 1, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd10,  8'd20,  8'd1,   8'd0,   8'd0,   1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd10,  8'd30,  8'd0,   8'd0,   8'd0,   0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd1,   8'd2,   8'd0,   8'd0,   8'd0,   0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd3,   8'd4,   8'd1,   8'd0,   8'd0,   0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd5,   8'd6,   8'd1,   8'd0,   8'd0,   0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   1, 1, 1, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, 0, 0, 15'd128, 16'd1, 16'd1);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1, 0, 0, 15'd128, 16'd1, 16'd1);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd10,  8'd30,  0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd10,  8'd20,  0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd3,   8'd4,   0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'hAA,  8'h55,  8'h0F,  8'h55,  8'hAA,  0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_PIXEL, 8'h55,  8'hAA,  8'hF0,  8'hAA,  8'h55,  0, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_NOP,   8'h00,  8'h00,  8'h00,  8'h00,  8'h00,  1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_CLEAR, 8'h00,  8'h00,  8'h00,  8'h00,  8'h00,  1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, 0, 0, 15'd0,   16'd0, 16'd0);
    add_row(MODE_READ,  8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1, 0, 0, 15'd0,   16'd0, 16'd0);
    foreach (dir_beats[i]) send_beat(dir_beats[i], dir_typed[i], dir_expect[i]);
    drain_results();

    // one pixel per row, same bin: drives the bin into saturation
    run_phase(11'd1,    16'd0,     330, 0, 1, 1, 0, 0);
    run_phase(11'd8,    16'd4,     300, 1, 0, 1, 0, 1);
    run_phase(11'd0,    16'd1,     100, 1, 0, 0, 0, 0);
    run_phase(11'd2047, 16'd65535, 250, 0, 0, 1, 0, 0);
    run_phase(11'd1024, 16'd2,     200, 0, 0, 0, 0, 0);
    run_phase(11'd2,    16'd65535, 300, 1, 0, 1, 0, 1);
    // sink holds off for a long stretch so the input side backs up
    run_phase(11'd16,   16'd5,     170, 1, 0, 1, 1, 0);

    repeat (20) @(posedge clk_i);
    $display("Beats: %0d pixel, %0d read, %0d clear, %0d no-op over widths 0..2047",
             beats_by_mode[MODE_PIXEL], beats_by_mode[MODE_READ],
             beats_by_mode[MODE_CLEAR], beats_by_mode[MODE_NOP]);
    $display("Results checked: %0d; occluded pairs %0d; counts on saturated bins %0d",
             results_checked, occluded_pairs, sat_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sjh_pkg.sv
sv/sjh_if.sv
sv/sjh_front.sv
sv/sjh_queue.sv
sv/sjh_back.sv
sv/stereo_joint_histogram_unit.sv
dv/stereo_joint_histogram_unit_tb.sv
